// ===== rtl/core/fractional_delay_line_interp_unit_defines.svh =====
// Assertion macros shared by the checker of the fractional delay line unit.
// No dependencies; included by the checker file.
`ifndef FRACTIONAL_DELAY_LINE_INTERP_UNIT_DEFINES_SVH
`define FRACTIONAL_DELAY_LINE_INTERP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define FDLI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fdli assertion failed");

// Next-cycle implication, disabled while rst is high.
`define FDLI_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fdli assertion failed");

`endif

// ===== rtl/core/fdli_pkg.sv =====
// Package for the fractional delay line unit: field widths, constants and
// the command struct between controller and datapath. No dependencies.
package fdli_pkg;

   localparam int SAMPLE_W = 24;
   localparam int DELAY_W  = 15;
   localparam int SPM_W    = 24;
   localparam int FRAC_W   = 16;
   localparam int PROD_W   = DELAY_W + SPM_W;
   localparam int DQ_W     = PROD_W - 4;

   localparam int unsigned DEPTH_DEFAULT = 131072;

   localparam logic [DELAY_W-1:0] DELAY_LIMIT = 15'd32000;
   localparam logic [SPM_W-1:0]   SPM_RESET   = 24'd2890138;

   // One strobe per datapath step, issued by the controller.
   typedef struct packed {
      logic load_in;
      logic mul_delay;
      logic addr_calc;
      logic rd_i0;
      logic rd_i1;
      logic wr_sample;
      logic mac;
      logic load_out;
   } cmd_type;

endpackage

// ===== rtl/core/fdli_ctrl.sv =====
// Controller of the fractional delay line unit: sequences one item through
// the datapath steps and owns the handshakes. Depends on fdli_pkg.
module fdli_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fdli_pkg::cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_CALC = 8'b0000_0010,
      ST_ADDR = 8'b0000_0100,
      ST_RD0  = 8'b0000_1000,
      ST_RD1  = 8'b0001_0000,
      ST_WR   = 8'b0010_0000,
      ST_MAC  = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.mul_delay = 1'b1;
            state_in      = ST_ADDR;
         end
         ST_ADDR: begin
            cmd.addr_calc = 1'b1;
            state_in      = ST_RD0;
         end
         ST_RD0: begin
            cmd.rd_i0 = 1'b1;
            state_in  = ST_RD1;
         end
         ST_RD1: begin
            cmd.rd_i1 = 1'b1;
            state_in  = ST_WR;
         end
         ST_WR: begin
            cmd.wr_sample = 1'b1;
            state_in      = ST_MAC;
         end
         ST_MAC: begin
            cmd.mac  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // The result waits here while the previous one is still held.
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/fdli_dpath.sv =====
// Datapath of the fractional delay line unit: delay scaling, read address
// generation, the sample store and the interpolator. Depends on fdli_pkg.
module fdli_dpath #(
   parameter int unsigned DEPTH = fdli_pkg::DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fdli_pkg::cmd_type                     cmd,
   input  logic signed [fdli_pkg::SAMPLE_W-1:0]  req_sample_in,
   input  logic        [fdli_pkg::DELAY_W-1:0]   req_delay_sixteenths_ms,
   input  logic                                  csr_write_enable,
   input  logic        [fdli_pkg::SPM_W-1:0]     csr_write_data,
   output logic signed [fdli_pkg::SAMPLE_W-1:0]  rsp_sample_out
);

   localparam int SW  = fdli_pkg::SAMPLE_W;
   localparam int FW  = fdli_pkg::FRAC_W;
   localparam int AW  = $clog2(DEPTH);
   localparam int PW  = AW + FW;
   localparam int CW  = (fdli_pkg::DQ_W > PW) ? fdli_pkg::DQ_W : PW;
   localparam int MW  = SW + 1 + FW + 1;
   localparam longint unsigned LIM_L   = (longint'(DEPTH) - 64'd2) << FW;
   localparam longint unsigned TOTAL_L = longint'(DEPTH) << FW;
   localparam logic [CW-1:0] LIM   = CW'(LIM_L);
   localparam logic [PW:0]   TOTAL = (PW + 1)'(TOTAL_L);
   localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);

   logic [fdli_pkg::SPM_W-1:0]   spm_ff, spm_in;
   logic [AW-1:0]                wp_ff, wp_in;
   logic                         wrapped_ff, wrapped_in;
   logic [SW-1:0]                sample_ff;
   logic [fdli_pkg::DELAY_W-1:0] dsat_ff;
   logic [fdli_pkg::PROD_W-1:0]  prod_ff;
   logic [AW-1:0]                i0_ff, i1_ff;
   logic [FW-1:0]                frac_ff;
   logic                         ok0_ff, ok1_ff;
   logic [SW-1:0]                history_ff [DEPTH];
   logic [SW-1:0]                rd_data_ff;
   logic signed [SW-1:0]         s0_ff, s1_ff;
   logic signed [MW-1:0]         mul_ff;
   logic signed [SW-1:0]         out_ff;

   logic [CW-1:0]        dq_c, dq_cl;
   logic [PW-1:0]        dq_p, base, pos;
   logic [PW:0]          pos_wrap;
   logic [AW-1:0]        i0, i1;
   logic [AW-1:0]        rd_addr;
   logic signed [SW:0]   diff;
   logic signed [MW-1:0] acc;

   // Configuration register and write pointer.
   always_comb begin
      spm_in     = csr_write_enable ? csr_write_data : spm_ff;
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (cmd.wr_sample) begin
         wp_in = (wp_ff == LAST) ? '0 : wp_ff + AW'(1);
         if (wp_ff == LAST) begin
            wrapped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spm_ff     <= fdli_pkg::SPM_RESET;
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         spm_ff     <= spm_in;
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
      end
   end

   // Read position: clamp the Q16 delay, then step back from the write pointer; also the interpolation terms.
   always_comb begin
      dq_c     = CW'(prod_ff[fdli_pkg::PROD_W-1:4]);
      dq_cl    = (dq_c > LIM) ? LIM : dq_c;
      dq_p     = PW'(dq_cl);
      base     = {wp_ff, {FW{1'b0}}};
      pos_wrap = {1'b0, base} + TOTAL - {1'b0, dq_p};
      pos      = (dq_p > base) ? pos_wrap[PW-1:0] : base - dq_p;
      i0       = pos[PW-1:FW];
      i1       = (i0 == LAST) ? '0 : i0 + AW'(1);
      rd_addr  = cmd.rd_i1 ? i1_ff : i0_ff;
      diff     = (SW + 1)'(s1_ff) - (SW + 1)'(s0_ff);
      acc      = (MW'(s0_ff) <<< FW) + mul_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         sample_ff <= req_sample_in;
         dsat_ff   <= (req_delay_sixteenths_ms > fdli_pkg::DELAY_LIMIT) ?
                      fdli_pkg::DELAY_LIMIT : req_delay_sixteenths_ms;
      end
      if (cmd.mul_delay) begin
         prod_ff <= fdli_pkg::PROD_W'(dsat_ff) * fdli_pkg::PROD_W'(spm_ff);
      end
      if (cmd.addr_calc) begin
         i0_ff   <= i0;
         i1_ff   <= i1;
         frac_ff <= pos[FW-1:0];
         // Entries are written in address order, so anything below the
         // write pointer, or anything at all after a wrap, holds real data.
         ok0_ff  <= wrapped_ff || (i0 < wp_ff);
         ok1_ff  <= wrapped_ff || (i1 < wp_ff);
      end
      if (cmd.rd_i1) begin
         s0_ff <= ok0_ff ? $signed(rd_data_ff) : '0;
      end
      if (cmd.wr_sample) begin
         s1_ff <= ok1_ff ? $signed(rd_data_ff) : '0;
      end
      if (cmd.mac) begin
         mul_ff <= MW'(diff) * $signed(MW'(frac_ff));
      end
      if (cmd.load_out) begin
         out_ff <= acc[FW+SW-1:FW];
      end
   end

   // Single-port sample store with registered read data.
   always_ff @(posedge clock) begin
      if (cmd.rd_i0 || cmd.rd_i1) begin
         rd_data_ff <= history_ff[rd_addr];
      end else if (cmd.wr_sample) begin
         history_ff[wp_ff] <= sample_ff;
      end
   end

   assign rsp_sample_out = out_ff;

endmodule

// ===== rtl/core/fractional_delay_line_interp_unit.sv =====
// rsp_valid rises once the controller has walked the item through its
// steps, later only if the previous result is still held. One item is in
// flight at a time: the next is taken when the controller's step sequence,
// shaped by the single memory port (two reads and one write per item), ends.
// Reset: synchronous, active high; the store needs no clearing pass because
// entries not yet written since reset are tracked by the write pointer.
module fractional_delay_line_interp_unit #(
   parameter int unsigned DEPTH = fdli_pkg::DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [fdli_pkg::SAMPLE_W-1:0]  req_sample_in,
   input  logic        [fdli_pkg::DELAY_W-1:0]   req_delay_sixteenths_ms,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [fdli_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   input  logic                                  csr_write_enable,
   input  logic        [fdli_pkg::SPM_W-1:0]     csr_write_data
);

   // The controller walks each transfer through these steps: register the
   // input, scale the delay by samples per millisecond, form the read
   // position, read the two neighboring samples, write the new sample, then
   // interpolate and hand the result to the output register.
   fdli_pkg::cmd_type cmd;

   fdli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // The datapath holds the configuration register, the write pointer, the
   // store and the interpolator. The output register lets a new transfer be
   // taken while the last result still waits for the consumer.
   fdli_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .req_sample_in           (req_sample_in),
      .req_delay_sixteenths_ms (req_delay_sixteenths_ms),
      .csr_write_enable        (csr_write_enable),
      .csr_write_data          (csr_write_data),
      .rsp_sample_out          (rsp_sample_out)
   );

endmodule

// ===== rtl/core/fdli_checker.sv =====
// Port-level checker for the fractional delay line unit, bound to the top.
// Depends on fdli_pkg and fractional_delay_line_interp_unit_defines.svh.
`include "fractional_delay_line_interp_unit_defines.svh"

module fdli_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [fdli_pkg::SAMPLE_W-1:0] rsp_sample_out
);

   logic [1:0] outstanding_ff, outstanding_in;
   logic       req_xfer, rsp_xfer;
   logic       rsp_stall;

   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   always_comb begin
      outstanding_in = outstanding_ff + 2'(req_xfer) - 2'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   `FDLI_ASSERT_NXT(a_reset_state, clock, 1'b0, reset, !rsp_valid && req_ready)
   `FDLI_ASSERT_NXT(a_one_in_flight, clock, reset, req_xfer, !req_ready)
   `FDLI_ASSERT_IMP(a_no_stray_result, clock, reset, rsp_valid, outstanding_ff != 2'd0)
   `FDLI_ASSERT_IMP(a_bounded_backlog, clock, reset, req_xfer, outstanding_ff <= 2'd1)
   `FDLI_ASSERT_NXT(a_result_held, clock, reset, rsp_stall, rsp_valid && $stable(rsp_sample_out))

endmodule

bind fractional_delay_line_interp_unit fdli_checker u_fdli_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out)
);

// ===== tb/sv/tb_fractional_delay_line_interp_unit.sv =====
// Self-checking testbench for the fractional delay line interpolation unit.
// Depends on fdli_pkg and the fractional_delay_line_interp_unit RTL only.
`timescale 1ns / 100ps

module tb_fractional_delay_line_interp_unit;

   localparam int                           SAMPLE_W    = fdli_pkg::SAMPLE_W;
   localparam int                           DELAY_W     = fdli_pkg::DELAY_W;
   localparam int                           SPM_W       = fdli_pkg::SPM_W;
   localparam logic [fdli_pkg::DELAY_W-1:0] DELAY_LIMIT = fdli_pkg::DELAY_LIMIT;
   localparam logic [fdli_pkg::SPM_W-1:0]   SPM_RESET   = fdli_pkg::SPM_RESET;

   localparam int unsigned STORE_DEPTH   = fdli_pkg::DEPTH_DEFAULT;
   localparam int          PHASE_COUNT   = 10;
   localparam int          PHASE_ITEMS   = 163;
   localparam int          DIRECTED_LEN  = 20;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          STALL_LIMIT   = 5000;
   localparam int          REPORT_LIMIT  = 10;
   localparam int          SETTLE_CYCLES = 20;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic        [DELAY_W-1:0]  delay;
   } delay_item_type;

   // Stimulus applied to the block. Every input is known from time zero.
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic        [DELAY_W-1:0]  req_delay_sixteenths_ms = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       csr_write_enable = 1'b0;
   logic        [SPM_W-1:0]    csr_write_data = '0;

   // Shadow copy of the delay line: history, write position and rate register.
   logic signed [SAMPLE_W-1:0] shadow_history [STORE_DEPTH];
   int unsigned                shadow_write_pos;
   logic        [SPM_W-1:0]    shadow_spm;

   delay_item_type             pending_items [$];
   logic signed [SAMPLE_W-1:0] expected_samples [$];

   int          fail_count;
   int          stall_cycles;
   int          stored_count;

   // Handshake bookkeeping shared between the rising-edge monitor and the
   // falling-edge drivers. A flag is set when a transfer is seen and cleared
   // by the falling-edge driver that reacts to it.
   bit             req_took;
   bit             rsp_took;
   int             req_gap;
   int             rsp_gap;
   bit             req_calm;
   bit             rsp_calm;
   bit             hold_request;
   int             hold_left;
   delay_item_type next_item;

   fractional_delay_line_interp_unit u_top (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_sample_in           (req_sample_in),
      .req_delay_sixteenths_ms (req_delay_sixteenths_ms),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_sample_out          (rsp_sample_out),
      .csr_write_enable        (csr_write_enable),
      .csr_write_data          (csr_write_data)
   );

   always #5 clock = ~clock;

   // Advances the shadow delay line by one sample and returns the value the
   // block must produce for it. The read is taken before the new sample is
   // stored, so a zero delay returns the oldest entry of the history.
   function automatic logic signed [SAMPLE_W-1:0] delay_line_step(
      input logic signed [SAMPLE_W-1:0] sample,
      input logic        [DELAY_W-1:0]  delay
   );
      longint unsigned total_q16;
      longint unsigned limit_q16;
      longint unsigned delay_clipped;
      longint unsigned delay_q16;
      longint unsigned read_q16;
      int unsigned     tap0;
      int unsigned     tap1;
      int unsigned     frac;
      longint          acc;
      longint          blended;
      total_q16 = longint'(STORE_DEPTH) << 16;
      limit_q16 = longint'(STORE_DEPTH - 2) << 16;
      // Delays past the 2000 ms mark saturate before scaling.
      delay_clipped = 64'(delay);
      if (delay_clipped > 64'(DELAY_LIMIT)) begin
         delay_clipped = 64'(DELAY_LIMIT);
      end
      delay_q16 = (delay_clipped * 64'(shadow_spm)) >> 4;
      // A delay longer than the store can hold stops two samples short of it.
      if (delay_q16 > limit_q16) begin
         delay_q16 = limit_q16;
      end
      read_q16 = (longint'(shadow_write_pos) << 16) + total_q16 - delay_q16;
      if (read_q16 >= total_q16) begin
         read_q16 = read_q16 - total_q16;
      end
      tap0 = 32'(read_q16 >> 16);
      tap1 = (tap0 + 1) % STORE_DEPTH;
      frac = 32'(read_q16 & 64'hFFFF);
      acc = longint'(shadow_history[tap0]) * longint'(65536 - frac)
          + longint'(shadow_history[tap1]) * longint'(frac);
      // Arithmetic shift gives the floor of the division.
      blended = acc >>> 16;
      shadow_history[shadow_write_pos] = sample;
      shadow_write_pos = (shadow_write_pos + 1) % STORE_DEPTH;
      return blended[SAMPLE_W-1:0];
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic signed [SAMPLE_W-1:0] want,
                                  input logic signed [SAMPLE_W-1:0] got);
      if (fail_count < REPORT_LIMIT) begin
         $display("mismatch (%s): expected %0d, got %0d", what, want, got);
      end
      fail_count++;
   endtask

   // Monitor: both channels are sampled at the rising edge, where every
   // input has settled since the falling edge that drove it. The predictor
   // runs on each request transfer and each response transfer is checked
   // against the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_samples.push_back(delay_line_step(req_sample_in,
                                                       req_delay_sixteenths_ms));
            req_took = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_took = 1'b1;
            if (expected_samples.size() == 0) begin
               report_mismatch("unexpected result", '0, rsp_sample_out);
            end else if (expected_samples[0] !== rsp_sample_out) begin
               report_mismatch("sample_out", expected_samples[0], rsp_sample_out);
               void'(expected_samples.pop_front());
            end else begin
               void'(expected_samples.pop_front());
            end
         end
      end
   end

   // Request driver. A new item goes out only after the previous transfer,
   // once its random gap has elapsed. With a gap of zero the valid simply
   // stays high into the next item.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_took) begin
         // The offered item has not been taken yet; hold it steady.
      end else begin
         req_took = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            next_item = pending_items.pop_front();
            req_sample_in           <= next_item.sample;
            req_delay_sixteenths_ms <= next_item.delay;
            req_valid               <= 1'b1;
            if ($urandom_range(0, 49) == 0) begin
               req_calm = ~req_calm;
            end
            req_gap = req_calm ? 0 : $urandom_range(0, 9);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response driver. After each transfer the receiver draws its own pause.
   // On request it also holds off for a long stretch so that the block
   // fills up and has to refuse new requests.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (rsp_took) begin
               rsp_took = 1'b0;
               if ($urandom_range(0, 49) == 0) begin
                  rsp_calm = ~rsp_calm;
               end
               rsp_gap = rsp_calm ? 0 : $urandom_range(0, 9);
            end
            if (rsp_gap > 0) begin
               rsp_gap--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // Watchdog: any cycle without a transfer on either channel counts toward
   // the limit, which is far above the longest legitimate quiet stretch.
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic queue_item(input logic signed [SAMPLE_W-1:0] sample,
                             input logic [DELAY_W-1:0] delay);
      delay_item_type item;
      item.sample = sample;
      item.delay  = delay;
      pending_items.push_back(item);
      stored_count++;
   endtask

   // Waits until every queued item has been transferred and every result
   // has come back, so the block is idle. The check runs at the rising edge,
   // where the drivers' updates from the falling edge have long settled.
   task automatic wait_drained();
      while (pending_items.size() != 0 || req_valid || expected_samples.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Register write while idle; the shadow copy is updated once the enable drops.
   task automatic write_rate(input logic [SPM_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      shadow_spm = value;
   endtask

   // Random phase: most delays reach back only into history written so far,
   // so the interpolation sees real data. The rest are noise over the whole
   // delay field, including the saturated band above 2000 ms.
   task automatic queue_random_phase(input int count);
      longint unsigned reach;
      logic signed [SAMPLE_W-1:0] sample;
      logic [DELAY_W-1:0] delay;
      int kind;
      for (int n = 0; n < count; n++) begin
         if (shadow_spm == 0) begin
            reach = 32767;
         end else begin
            reach = (longint'(stored_count) << 20) / longint'(shadow_spm);
            if (reach > 32767) begin
               reach = 32767;
            end
         end
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            delay = DELAY_W'($urandom_range(0, 32767));
         end else if (kind == 1) begin
            delay = DELAY_W'($urandom_range(32000, 32767));
         end else begin
            delay = DELAY_W'($urandom_range(0, 32'(reach)));
         end
         kind = $urandom_range(0, 15);
         if (kind == 0) begin
            sample = 24'sh7FFFFF;
         end else if (kind == 1) begin
            sample = 24'sh800000;
         end else begin
            sample = SAMPLE_W'($urandom());
         end
         queue_item(sample, delay);
      end
   endtask

   logic [SPM_W-1:0] rate_plan [PHASE_COUNT];
   int directed_samples [DIRECTED_LEN] = '{
      8388607, -8388608, -1, 0, 8388607, -8388608, 8388607, 1, -8388608, 8388607,
      0, -1, 8388607, -8388608, 12345, -4096, 8388607, 0, -8388608, 1};
   int directed_delays [DIRECTED_LEN] = '{
      0, 0, 32767, 32001, 32000, 1, 1, 2, 3, 0,
      4, 5, 6, 7, 1, 2, 3, 0, 32767, 1};

   initial begin
      foreach (shadow_history[i]) begin
         shadow_history[i] = '0;
      end
      shadow_write_pos = 0;
      shadow_spm       = SPM_RESET;
      fail_count       = 0;
      stored_count     = 0;

      // Rate settings: the reset value first, then both ends of the legal
      // range, zero, the all-ones register, random values and a fixed one, and the reset value again.
      rate_plan[0] = SPM_RESET;
      rate_plan[1] = 24'd65536;
      rate_plan[2] = 24'd12582912;
      rate_plan[3] = 24'd0;
      rate_plan[4] = 24'hFFFFFF;
      rate_plan[5] = SPM_W'($urandom());
      rate_plan[6] = SPM_W'($urandom_range(65536, 12582912));
      rate_plan[7] = 24'd196608;
      rate_plan[8] = SPM_W'($urandom());
      rate_plan[9] = SPM_RESET;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset rate: extreme samples, zero delay,
      // saturated delays and short delays that interpolate between extremes.
      for (int n = 0; n < DIRECTED_LEN; n++) begin
         queue_item(SAMPLE_W'(directed_samples[n]), DELAY_W'(directed_delays[n]));
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase != 0) begin
            wait_drained();
            write_rate(rate_plan[phase]);
            @(posedge clock);
         end
         // One long receiver hold-off while the sender keeps offering.
         if (phase == 2) begin
            hold_request = 1'b1;
         end
         queue_random_phase(PHASE_ITEMS);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      fail_count += expected_samples.size();

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== fractional_delay_line_interp_unit.f =====
+incdir+rtl/core
rtl/core/fdli_pkg.sv
rtl/core/fdli_ctrl.sv
rtl/core/fdli_dpath.sv
rtl/core/fractional_delay_line_interp_unit.sv
rtl/core/fdli_checker.sv
tb/sv/tb_fractional_delay_line_interp_unit.sv
